// ===== rtl/knc_pkg.sv =====
// Shared types and constants for the k-nearest candidate list.
// No dependencies; imported by knc_cell and k_nearest_candidate_list.
`timescale 1ns / 1ps

package knc_pkg;

    localparam int DIST_W = 32;
    localparam int NODE_W = 10;
    localparam int OUT_W  = 11;

    typedef struct packed {
        logic [DIST_W-1:0] dist_key;
        logic [NODE_W-1:0] node;
    } slot_t;

    typedef struct packed {
        logic insert;   // place the broadcast candidate this cycle
        logic drain;    // shift the whole row toward the head
    } cell_ctl_t;

    localparam slot_t EMPTY_SLOT = '{dist_key: {DIST_W{1'b1}}, node: '0};

endpackage

// ===== rtl/k_nearest_candidate_list.sv =====
// A candidate without row_end is absorbed into the chain by the clock edge that accepts it.
// Throughput: one candidate per cycle while collecting; a row_end transaction
// then holds off input while the chain drains all NEIGHBOURS slots into the
// output register, one slot per cycle while the output is free, and then
// while the sink node goes out.
// Reset: chain empty (maximum distance, node 0), node_count 1, no output pending.
// Depends on knc_pkg and knc_cell.
`timescale 1ns / 1ps

module k_nearest_candidate_list
    import knc_pkg::*;
#(
    parameter int NEIGHBOURS = 8,
    parameter int MAX_NODES  = 1023
)
(
    input  logic              clk,
    input  logic              rst_n,
    // candidate stream
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [NODE_W-1:0] row_node,
    input  logic [NODE_W-1:0] column_node,
    input  logic [DIST_W-1:0] distance,
    input  logic              row_end,
    // neighbour stream
    output logic              out_valid,
    input  logic              out_ready,
    output logic [OUT_W-1:0]  neighbour_node,
    output logic              last_of_row,
    // configuration
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [NODE_W-1:0] node_count
);

    localparam int CNT_W = (NEIGHBOURS > 1) ? $clog2(NEIGHBOURS) : 1;

    typedef enum logic [1:0] {
        S_COLLECT,
        S_DRAIN,
        S_SINK
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   drain_cnt_reg, drain_cnt_next;
    logic [NODE_W-1:0]  node_count_reg;
    logic               out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]   neighbour_reg, neighbour_next;
    logic               last_reg, last_next;

    slot_t              chain_slot [NEIGHBOURS];
    logic               chain_le   [NEIGHBOURS];
    cell_ctl_t          ctl;
    slot_t              cand;
    logic               in_fire;
    logic               out_free;

    // Configuration: always ready; clamp the node count to the supported range.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_W'(1);
        end
        else if (cfg_valid)
        begin
            if (32'(node_count) > 32'(MAX_NODES))
            begin
                node_count_reg <= NODE_W'(MAX_NODES);
            end
            else
            begin
                node_count_reg <= node_count;
            end
        end
    end

    // Input is taken only while collecting; the row_end transaction itself
    // still inserts its candidate before the drain starts.
    assign in_ready = (state_reg == S_COLLECT);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign cand.dist_key = distance;
    assign cand.node     = column_node;
    assign ctl.insert    = in_fire && (row_node != column_node);
    assign ctl.drain     = (state_reg == S_DRAIN) && out_free;

    // Chain of cells: insertion shifts toward the tail, drain toward the head.
    // Draining pulls empty slots in from the tail, which clears the list.
    for (genvar k = 0; k < NEIGHBOURS; k++)
    begin : g_cell
        slot_t left_slot;
        logic  left_le;
        slot_t right_slot;

        if (k == 0)
        begin : g_head
            assign left_slot = EMPTY_SLOT;
            assign left_le   = 1'b0;
        end
        else
        begin : g_body
            assign left_slot = chain_slot[k-1];
            assign left_le   = chain_le[k-1];
        end

        if (k == NEIGHBOURS - 1)
        begin : g_tail
            assign right_slot = EMPTY_SLOT;
        end
        else
        begin : g_inner
            assign right_slot = chain_slot[k+1];
        end

        knc_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .cand       (cand),
            .left_slot  (left_slot),
            .left_le    (left_le),
            .right_slot (right_slot),
            .slot       (chain_slot[k]),
            .le         (chain_le[k])
        );
    end

    // Sequencer: collect, drain the chain head into the output register,
    // then emit the sink node.
    always_comb
    begin
        state_next     = state_reg;
        drain_cnt_next = drain_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        neighbour_next = neighbour_reg;
        last_next      = last_reg;

        unique case (state_reg)
            S_COLLECT:
            begin
                if (in_fire && row_end)
                begin
                    state_next     = S_DRAIN;
                    drain_cnt_next = '0;
                end
            end
            S_DRAIN:
            begin
                if (out_free)
                begin
                    // drop empty slots; present occupied ones in order
                    if (chain_slot[0].node != '0)
                    begin
                        out_valid_next = 1'b1;
                        neighbour_next = OUT_W'(chain_slot[0].node);
                        last_next      = 1'b0;
                    end
                    if (drain_cnt_reg == CNT_W'(NEIGHBOURS - 1))
                    begin
                        state_next = S_SINK;
                    end
                    else
                    begin
                        drain_cnt_next = drain_cnt_reg + CNT_W'(1);
                    end
                end
            end
            S_SINK:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    neighbour_next = OUT_W'(node_count_reg) + OUT_W'(1);
                    last_next      = 1'b1;
                    state_next     = S_COLLECT;
                end
            end
            default:
            begin
                state_next = S_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_COLLECT;
            drain_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
            neighbour_reg <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            drain_cnt_reg <= drain_cnt_next;
            out_valid_reg <= out_valid_next;
            neighbour_reg <= neighbour_next;
            last_reg      <= last_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign neighbour_node = neighbour_reg;
    assign last_of_row    = last_reg;

    // A row_end transaction always starts a drain.
    a_row_end_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && row_end) |=> (state_reg == S_DRAIN))
        else $error("row_end transaction did not start a drain");

    // A pending sink entry is always gone before the next sink is due.
    a_sink_not_in_sink: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_of_row) |-> (state_reg != S_SINK))
        else $error("sink entry still pending at the next sink");

    // Neighbour entries never carry the empty-slot marker.
    a_no_empty_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last_of_row) |-> (neighbour_node != '0))
        else $error("empty slot emitted as neighbour");

    // The full drain leaves the chain empty before the sink goes out.
    a_cleared_at_sink: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SINK) |-> (chain_slot[0].node == '0))
        else $error("chain not cleared after drain");

endmodule

// ===== rtl/knc_cell.sv =====
// One slot of the sorted candidate chain.
// Depends on knc_pkg for slot_t, cell_ctl_t and EMPTY_SLOT.
`timescale 1ns / 1ps

module knc_cell
    import knc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_ctl_t ctl,
    input  slot_t     cand,
    input  slot_t     left_slot,
    input  logic      left_le,
    input  slot_t     right_slot,
    output slot_t     slot,
    output logic      le
);

    slot_t slot_reg;
    slot_t slot_next;

    // Candidate belongs at or before this slot.
    assign le   = (cand.dist_key <= slot_reg.dist_key);
    assign slot = slot_reg;

    always_comb
    begin
        slot_next = slot_reg;
        if (ctl.drain)
        begin
            slot_next = right_slot;
        end
        else if (ctl.insert)
        begin
            if (left_le)
            begin
                slot_next = left_slot;      // shift back behind the new entry
            end
            else if (le)
            begin
                slot_next = cand;           // first slot not smaller: take it
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= EMPTY_SLOT;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

endmodule
